FILE: design/nms_pkg.sv
// Shared types and constants for the box non-maximum suppression block.
`timescale 1ns / 1ps
package nms_pkg;

   // Fixed widths of the external fields.
   localparam int IO_W     = 16;
   localparam int CLASS_W  = 7;
   localparam int THR_W    = 16;
   localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

   // Register stages of the overlap unit; they also form part of the ring.
   localparam int IOU_STAGES = 4;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_BOXES  = 64;
   localparam int DEF_COORD_BITS = 16;
   localparam int DEF_SCORE_BITS = 16;

   // Status bits that travel with each stored box.
   typedef struct packed {
      logic valid;
      logic done;
      logic mark;
   } flag_type;

   // Commands from the sequencer to every cell of the chain.
   typedef struct packed {
      logic clear;
      logic insert;
      logic rotate;
   } ctl_type;

   typedef enum logic [2:0] {
      ST_LOAD    = 3'b001,
      ST_SEARCH  = 3'b010,
      ST_COMPARE = 3'b100
   } state_type;

endpackage

FILE: design/box_non_max_suppression.sv
// Load: one box per cycle, inserted in score order into a chain of MAX_BOXES cells.
// Suppression: the chain and the 4-stage overlap unit form a ring of MAX_BOXES+4 slots,
// rotated once per kept box, and held while the result register is full and not taken.
// A new set is taken once the previous one has finished suppression.
// Reset (synchronous): control, cell flags and box count clear, threshold to 29491.
`timescale 1ns / 1ps
module box_non_max_suppression #(
   parameter int MAX_BOXES  = nms_pkg::DEF_MAX_BOXES,
   parameter int COORD_BITS = nms_pkg::DEF_COORD_BITS,
   parameter int SCORE_BITS = nms_pkg::DEF_SCORE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [nms_pkg::IO_W-1:0]      req_box_left,
   input  logic [nms_pkg::IO_W-1:0]      req_box_top,
   input  logic [nms_pkg::IO_W-1:0]      req_box_right,
   input  logic [nms_pkg::IO_W-1:0]      req_box_bottom,
   input  logic [nms_pkg::IO_W-1:0]      req_box_score,
   input  logic [nms_pkg::CLASS_W-1:0]   req_box_class,
   input  logic                          req_set_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nms_pkg::IO_W-1:0]      rsp_kept_left,
   output logic [nms_pkg::IO_W-1:0]      rsp_kept_top,
   output logic [nms_pkg::IO_W-1:0]      rsp_kept_right,
   output logic [nms_pkg::IO_W-1:0]      rsp_kept_bottom,
   output logic [nms_pkg::IO_W-1:0]      rsp_kept_score,
   output logic [nms_pkg::CLASS_W-1:0]   rsp_kept_class,
   output logic                          rsp_kept_last,
   input  logic                          csr_we,
   input  logic [nms_pkg::THR_W-1:0]     csr_wdata
);
   import nms_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int PW   = 6 * C + CLASS_W;
   localparam int AW   = 2 * C;
   localparam int CW   = $clog2(MAX_BOXES + 1);
   localparam int RING = MAX_BOXES + IOU_STAGES;
   localparam int RW   = $clog2(RING);

   // Threshold register.
   logic [THR_W-1:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   // Incoming box, trimmed to the configured widths, with its area.
   logic [C-1:0]          nl, nt, nr, nb, nw, nh;
   logic [AW-1:0]         narea;
   logic [SCORE_BITS-1:0] nscore;
   logic [PW-1:0]         npay;

   assign nl     = C'(req_box_left);
   assign nt     = C'(req_box_top);
   assign nr     = C'(req_box_right);
   assign nb     = C'(req_box_bottom);
   assign nw     = (nr > nl) ? nr - nl : '0;
   assign nh     = (nb > nt) ? nb - nt : '0;
   assign narea  = AW'(nw) * AW'(nh);
   assign nscore = SCORE_BITS'(req_box_score);
   assign npay   = {req_box_class, narea, nb, nr, nt, nl};

   // Sequencer state.
   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [RW-1:0]    cnt_ff, cnt_in;
   ctl_type          ctl;
   logic             accept, adv, cand, latch, finish, out_wr;

   // Chain of cells.
   logic [SCORE_BITS-1:0] cell_score [MAX_BOXES];
   logic [PW-1:0]         cell_pay [MAX_BOXES];
   flag_type              cell_fl [MAX_BOXES];
   logic                  cell_gt [MAX_BOXES];

   // Ring return path from the overlap unit.
   logic [SCORE_BITS-1:0] ret_score;
   logic [PW-1:0]         ret_pay;
   flag_type              ret_fl;
   flag_type              head_fl;

   // Keeper, pending result and output register.
   logic [PW-1:0]         keep_ff;
   logic [PW-1:0]         pend_pay_ff;
   logic [SCORE_BITS-1:0] pend_score_ff;
   logic                  pend_valid_ff;
   logic                  rsp_valid_ff;
   logic [PW-1:0]         out_pay_ff;
   logic [SCORE_BITS-1:0] out_score_ff;
   logic                  out_last_ff;

   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign cand      = cell_fl[0].valid && !cell_fl[0].done && !cell_fl[0].mark;
   assign latch     = (state_ff == ST_SEARCH) && adv && cand;
   assign finish    = (state_ff == ST_SEARCH) && adv && !cell_fl[0].valid;
   assign out_wr    = (latch && pend_valid_ff) || finish;

   always_comb begin
      ctl.clear  = finish;
      ctl.insert = accept && (count_ff < CW'(MAX_BOXES));
      ctl.rotate = ((state_ff == ST_SEARCH) || (state_ff == ST_COMPARE)) && adv;
   end

   // The head box is marked done as it leaves when it becomes the keeper.
   always_comb begin
      head_fl      = cell_fl[0];
      head_fl.done = cell_fl[0].done | latch;
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_BOXES; gi++) begin : g_cell
         logic                  p_gt;
         logic [SCORE_BITS-1:0] p_score, x_score;
         logic [PW-1:0]         p_pay, x_pay;
         flag_type              p_fl, x_fl;
         if (gi == 0) begin : g_first
            assign p_gt    = 1'b0;
            assign p_score = '0;
            assign p_pay   = '0;
            assign p_fl    = '0;
         end else begin : g_mid
            assign p_gt    = cell_gt[gi-1];
            assign p_score = cell_score[gi-1];
            assign p_pay   = cell_pay[gi-1];
            assign p_fl    = cell_fl[gi-1];
         end
         if (gi == MAX_BOXES - 1) begin : g_last
            assign x_score = ret_score;
            assign x_pay   = ret_pay;
            assign x_fl    = ret_fl;
         end else begin : g_inner
            assign x_score = cell_score[gi+1];
            assign x_pay   = cell_pay[gi+1];
            assign x_fl    = cell_fl[gi+1];
         end
         nms_cell #(
            .PAY_W   (PW),
            .SCORE_W (SCORE_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .new_score  (nscore),
            .new_pay    (npay),
            .prev_gt    (p_gt),
            .prev_score (p_score),
            .prev_pay   (p_pay),
            .prev_flags (p_fl),
            .next_score (x_score),
            .next_pay   (x_pay),
            .next_flags (x_fl),
            .score      (cell_score[gi]),
            .pay        (cell_pay[gi]),
            .flags      (cell_fl[gi]),
            .gt         (cell_gt[gi])
         );
      end
   endgenerate

   nms_iou #(
      .COORD_W (C),
      .SCORE_W (SCORE_BITS)
   ) u_iou (
      .clock     (clock),
      .reset     (reset),
      .adv       (ctl.rotate),
      .clr       (finish),
      .cmp       (state_ff == ST_COMPARE),
      .thr       (thr_ff),
      .keep_pay  (keep_ff),
      .in_score  (cell_score[0]),
      .in_pay    (cell_pay[0]),
      .in_flags  (head_fl),
      .out_score (ret_score),
      .out_pay   (ret_pay),
      .out_flags (ret_fl)
   );

   // Next-state logic: load, search for the next keeper, one compare lap per keeper.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cnt_in   = cnt_ff;
      if (ctl.insert) begin
         count_in = count_ff + 1'b1;
      end
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_set_end) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (finish) begin
               state_in = ST_LOAD;
               count_in = '0;
            end else if (latch) begin
               state_in = ST_COMPARE;
               cnt_in   = RW'(RING - 2);
            end
         end
         ST_COMPARE: begin
            if (adv) begin
               if (cnt_ff == '0) begin
                  state_in = ST_SEARCH;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cnt_ff   <= cnt_in;
      end
   end

   // A kept box waits as pending until the next keeper or the end of the set
   // tells whether it is the final one.
   always_ff @(posedge clock) begin
      if (latch) begin
         keep_ff       <= cell_pay[0];
         pend_pay_ff   <= cell_pay[0];
         pend_score_ff <= cell_score[0];
      end
      if (out_wr) begin
         out_pay_ff   <= pend_pay_ff;
         out_score_ff <= pend_score_ff;
         out_last_ff  <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (latch) begin
            pend_valid_ff <= 1'b1;
         end else if (finish) begin
            pend_valid_ff <= 1'b0;
         end
         if (out_wr) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result transaction outputs.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kept_left   = IO_W'(out_pay_ff[C-1:0]);
   assign rsp_kept_top    = IO_W'(out_pay_ff[2*C-1:C]);
   assign rsp_kept_right  = IO_W'(out_pay_ff[3*C-1:2*C]);
   assign rsp_kept_bottom = IO_W'(out_pay_ff[4*C-1:3*C]);
   assign rsp_kept_score  = IO_W'(out_score_ff);
   assign rsp_kept_class  = out_pay_ff[PW-1:6*C];
   assign rsp_kept_last   = out_last_ff;

`ifndef SYNTHESIS
   // The output register is only loaded when it is free or being emptied.
   assert property (@(posedge clock) disable iff (reset)
      out_wr |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   // The end of a set empties the chain and returns to loading.
   assert property (@(posedge clock) disable iff (reset)
      finish |=> (state_ff == ST_LOAD) && !cell_fl[0].valid && (count_ff == '0))
      else $error("set did not close cleanly");

   // A compare lap ends in search.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_COMPARE) && adv && (cnt_ff == '0)) |=> (state_ff == ST_SEARCH))
      else $error("compare lap did not return to search");

   // The box count never exceeds the chain length.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BOXES))
      else $error("box count overflow");

   // The end of a set always has a pending kept box to mark as final.
   assert property (@(posedge clock) disable iff (reset)
      finish |-> pend_valid_ff)
      else $error("set ended without a kept box");
`endif

endmodule

FILE: design/nms_cell.sv
// One cell of the box chain: sorted insertion while loading, rotation while suppressing.
`timescale 1ns / 1ps
module nms_cell #(
   parameter int PAY_W   = 103,
   parameter int SCORE_W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nms_pkg::ctl_type      ctl,
   input  logic [SCORE_W-1:0]    new_score,
   input  logic [PAY_W-1:0]      new_pay,
   input  logic                  prev_gt,
   input  logic [SCORE_W-1:0]    prev_score,
   input  logic [PAY_W-1:0]      prev_pay,
   input  nms_pkg::flag_type     prev_flags,
   input  logic [SCORE_W-1:0]    next_score,
   input  logic [PAY_W-1:0]      next_pay,
   input  nms_pkg::flag_type     next_flags,
   output logic [SCORE_W-1:0]    score,
   output logic [PAY_W-1:0]      pay,
   output nms_pkg::flag_type     flags,
   output logic                  gt
);
   import nms_pkg::*;

   logic [SCORE_W-1:0] score_ff, score_in;
   logic [PAY_W-1:0]   pay_ff, pay_in;
   flag_type           flags_ff, flags_in;
   flag_type           new_flags;

   // The new box goes ahead of this cell when the cell is empty or scores lower.
   // Equal scores stay ahead, which keeps ties in load order.
   assign gt = !flags_ff.valid || (score_ff < new_score);

   always_comb begin
      new_flags       = '0;
      new_flags.valid = 1'b1;
      score_in        = score_ff;
      pay_in          = pay_ff;
      flags_in        = flags_ff;
      if (ctl.clear) begin
         flags_in = '0;
      end else if (ctl.insert) begin
         if (gt) begin
            if (prev_gt) begin
               score_in = prev_score;
               pay_in   = prev_pay;
               flags_in = prev_flags;
            end else begin
               score_in = new_score;
               pay_in   = new_pay;
               flags_in = new_flags;
            end
         end
      end else if (ctl.rotate) begin
         score_in = next_score;
         pay_in   = next_pay;
         flags_in = next_flags;
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
      pay_ff   <= pay_in;
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   assign score = score_ff;
   assign pay   = pay_ff;
   assign flags = flags_ff;

endmodule

FILE: design/nms_iou.sv
// Pipelined overlap test of one box against the current keeper, part of the rotation ring.
`timescale 1ns / 1ps
module nms_iou #(
   parameter int COORD_W = 16,
   parameter int SCORE_W = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          clr,
   input  logic                          cmp,
   input  logic [nms_pkg::THR_W-1:0]     thr,
   input  logic [6*COORD_W+nms_pkg::CLASS_W-1:0] keep_pay,
   input  logic [SCORE_W-1:0]            in_score,
   input  logic [6*COORD_W+nms_pkg::CLASS_W-1:0] in_pay,
   input  nms_pkg::flag_type             in_flags,
   output logic [SCORE_W-1:0]            out_score,
   output logic [6*COORD_W+nms_pkg::CLASS_W-1:0] out_pay,
   output nms_pkg::flag_type             out_flags
);
   import nms_pkg::*;

   localparam int C  = COORD_W;
   localparam int PW = 6 * C + CLASS_W;
   localparam int AW = 2 * C;
   localparam int CMP_W = 80;

   // Field extraction for the keeper and the incoming box.
   logic [C-1:0]  kl, kt, kr, kb, el, et, er, eb;
   logic [AW-1:0] ka, ea;
   logic [C-1:0]  ix0, ix1, iy0, iy1, iw_in, ih_in;

   assign kl = keep_pay[C-1:0];
   assign kt = keep_pay[2*C-1:C];
   assign kr = keep_pay[3*C-1:2*C];
   assign kb = keep_pay[4*C-1:3*C];
   assign ka = keep_pay[6*C-1:4*C];
   assign el = in_pay[C-1:0];
   assign et = in_pay[2*C-1:C];
   assign er = in_pay[3*C-1:2*C];
   assign eb = in_pay[4*C-1:3*C];
   assign ea = in_pay[6*C-1:4*C];

   // Clamped intersection extents.
   assign ix0   = (kl > el) ? kl : el;
   assign ix1   = (kr < er) ? kr : er;
   assign iy0   = (kt > et) ? kt : et;
   assign iy1   = (kb < eb) ? kb : eb;
   assign iw_in = (ix1 > ix0) ? ix1 - ix0 : '0;
   assign ih_in = (iy1 > iy0) ? iy1 - iy0 : '0;

   // Payload and flags travel alongside the arithmetic.
   logic [SCORE_W-1:0] sc_ff [IOU_STAGES];
   logic [PW-1:0]      pay_ff [IOU_STAGES];
   flag_type           fl_ff [IOU_STAGES];
   logic [IOU_STAGES-1:0] cmp_ff;
   flag_type           fl0_in;
   logic               cmp0_in;

   logic [C-1:0]   iw_ff, ih_ff;
   logic [AW:0]    asum0_ff, asum1_ff;
   logic [AW-1:0]  inter1_ff, inter2_ff, inter3_ff;
   logic [AW:0]    uni2_ff;
   logic [63:0]    uni_wide;
   logic [47:0]    plo_ff, phi_ff;
   logic           nz_ff;
   logic [CMP_W-1:0] lhs, rhs;
   logic           sup;

   assign fl0_in  = clr ? '0 : in_flags;
   assign cmp0_in = cmp && in_flags.valid && !in_flags.done && !in_flags.mark;
   assign uni_wide = 64'(uni2_ff);

   // Stage registers: extents, product, union, threshold products.
   always_ff @(posedge clock) begin
      if (adv) begin
         sc_ff[0]  <= in_score;
         pay_ff[0] <= in_pay;
         iw_ff     <= iw_in;
         ih_ff     <= ih_in;
         asum0_ff  <= (AW+1)'(ka) + (AW+1)'(ea);
         inter1_ff <= AW'(iw_ff) * AW'(ih_ff);
         asum1_ff  <= asum0_ff;
         inter2_ff <= inter1_ff;
         uni2_ff   <= asum1_ff - (AW+1)'(inter1_ff);
         inter3_ff <= inter2_ff;
         plo_ff    <= 48'(thr) * 48'(uni_wide[31:0]);
         phi_ff    <= 48'(thr) * 48'(uni_wide[63:32]);
         nz_ff     <= (uni2_ff != '0);
         for (int s = 1; s < IOU_STAGES; s++) begin
            sc_ff[s]  <= sc_ff[s-1];
            pay_ff[s] <= pay_ff[s-1];
         end
      end
   end

   // Flags and compare enables are control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < IOU_STAGES; s++) begin
            fl_ff[s] <= '0;
         end
         cmp_ff <= '0;
      end else if (clr) begin
         for (int s = 0; s < IOU_STAGES; s++) begin
            fl_ff[s] <= '0;
         end
         cmp_ff <= '0;
      end else if (adv) begin
         fl_ff[0]  <= fl0_in;
         cmp_ff[0] <= cmp0_in;
         for (int s = 1; s < IOU_STAGES; s++) begin
            fl_ff[s]  <= fl_ff[s-1];
            cmp_ff[s] <= cmp_ff[s-1];
         end
      end
   end

   // Suppress when inter * 65536 > thr * union, and never on an empty union.
   assign lhs = CMP_W'(inter3_ff) << 16;
   assign rhs = (CMP_W'(phi_ff) << 32) + CMP_W'(plo_ff);
   assign sup = cmp_ff[IOU_STAGES-1] && nz_ff && (lhs > rhs);

   always_comb begin
      out_flags      = fl_ff[IOU_STAGES-1];
      out_flags.mark = fl_ff[IOU_STAGES-1].mark | sup;
   end
   assign out_score = sc_ff[IOU_STAGES-1];
   assign out_pay   = pay_ff[IOU_STAGES-1];

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the box non-maximum suppression block.
`timescale 1ns / 1ps
module testbench;
   import nms_pkg::*;

   localparam int BOXES     = DEF_MAX_BOXES;
   localparam int WATCH_MAX = 200000;

   // One candidate box as it is offered on the request side.
   typedef struct packed {
      logic [IO_W-1:0]    left;
      logic [IO_W-1:0]    top;
      logic [IO_W-1:0]    right;
      logic [IO_W-1:0]    bottom;
      logic [IO_W-1:0]    score;
      logic [CLASS_W-1:0] cls;
      logic               last;
   } box_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [IO_W-1:0] req_box_left, req_box_top, req_box_right, req_box_bottom, req_box_score;
   logic [CLASS_W-1:0] req_box_class;
   logic req_set_end;
   logic rsp_valid;
   logic rsp_ready;
   logic [IO_W-1:0] rsp_kept_left, rsp_kept_top, rsp_kept_right, rsp_kept_bottom;
   logic [IO_W-1:0] rsp_kept_score;
   logic [CLASS_W-1:0] rsp_kept_class;
   logic rsp_kept_last;
   logic csr_we;
   logic [THR_W-1:0] csr_wdata;

   box_type pending_boxes[$];
   box_type kept_boxes[$];
   box_type set_boxes[$];
   logic [THR_W-1:0] overlap_limit;
   int errors;
   int idle_cycles;
   int gap_left;
   int stall_left;
   int hold_off;
   bit stimulus_done;

   box_non_max_suppression u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_box_left(req_box_left), .req_box_top(req_box_top),
      .req_box_right(req_box_right), .req_box_bottom(req_box_bottom),
      .req_box_score(req_box_score), .req_box_class(req_box_class),
      .req_set_end(req_set_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_kept_left(rsp_kept_left), .rsp_kept_top(rsp_kept_top),
      .rsp_kept_right(rsp_kept_right), .rsp_kept_bottom(rsp_kept_bottom),
      .rsp_kept_score(rsp_kept_score), .rsp_kept_class(rsp_kept_class),
      .rsp_kept_last(rsp_kept_last),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] span_of(logic [IO_W-1:0] lo, logic [IO_W-1:0] hi);
      return (hi > lo) ? 32'(hi - lo) : 32'd0;
   endfunction

   // True when the overlap of two boxes is above the current limit.
   function automatic bit too_close(box_type a, box_type b);
      logic [31:0] iw, ih;
      logic [63:0] inter, area_a, area_b, joint_area;
      logic [95:0] lhs, rhs;
      iw = span_of((a.left > b.left) ? a.left : b.left, (a.right < b.right) ? a.right : b.right);
      ih = span_of((a.top > b.top) ? a.top : b.top, (a.bottom < b.bottom) ? a.bottom : b.bottom);
      inter = iw * ih;
      area_a = span_of(a.left, a.right) * span_of(a.top, a.bottom);
      area_b = span_of(b.left, b.right) * span_of(b.top, b.bottom);
      joint_area = area_a + area_b - inter;
      if (joint_area == 0) return 1'b0;
      lhs = {32'd0, inter} << 16;
      rhs = 96'(overlap_limit) * 96'(joint_area);
      return lhs > rhs;
   endfunction

   // Stores an accepted box; at the end of a set computes the surviving boxes.
   task automatic suppress_set(box_type b);
      box_type ranked[$];
      bit dropped[$];
      box_type kb;
      int k;
      if (set_boxes.size() < BOXES) set_boxes = {set_boxes, b};
      if (!b.last) return;
      foreach (set_boxes[i]) begin
         k = ranked.size();
         while (k > 0 && ranked[k-1].score < set_boxes[i].score) k--;
         ranked.insert(k, set_boxes[i]);
         dropped = {dropped, 1'b0};
      end
      foreach (ranked[i]) begin
         if (!dropped[i]) begin
            kb = ranked[i];
            kb.last = 1'b0;
            kept_boxes = {kept_boxes, kb};
            for (int j = i + 1; j < ranked.size(); j++)
               if (!dropped[j] && too_close(ranked[i], ranked[j])) dropped[j] = 1'b1;
         end
      end
      kept_boxes[kept_boxes.size() - 1].last = 1'b1;
      set_boxes.delete();
   endtask

   function automatic box_type random_box(bit last, int cluster);
      box_type b;
      logic [IO_W-1:0] x, y;
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
         // Boxes near a shared center so that overlap varies widely.
         x = IO_W'(cluster * 3000 + $urandom_range(0, 400));
         y = IO_W'(cluster * 2000 + $urandom_range(0, 400));
         b.left = x;
         b.top = y;
         b.right = x + IO_W'($urandom_range(0, 1200));
         b.bottom = y + IO_W'($urandom_range(0, 1200));
      end else begin
         b.left = IO_W'($urandom);
         b.top = IO_W'($urandom);
         b.right = IO_W'($urandom);
         b.bottom = IO_W'($urandom);
      end
      b.score = ($urandom_range(0, 3) == 0) ? IO_W'($urandom_range(0, 3)) : IO_W'($urandom);
      b.cls = CLASS_W'($urandom);
      b.last = last;
      return b;
   endfunction

   function automatic box_type make_box(int l, int t, int r, int bt, int s, int c, bit last);
      box_type b;
      b.left = IO_W'(l);
      b.top = IO_W'(t);
      b.right = IO_W'(r);
      b.bottom = IO_W'(bt);
      b.score = IO_W'(s);
      b.cls = CLASS_W'(c);
      b.last = last;
      return b;
   endfunction

   task automatic queue_random_set(int count);
      int cluster;
      cluster = $urandom_range(0, 3);
      for (int i = 0; i < count; i++)
         pending_boxes = {pending_boxes, random_box(i == count - 1, cluster)};
   endtask

   // Waits until every queued box is taken and every result has arrived.
   task automatic drain();
      while (pending_boxes.size() != 0 || req_valid || kept_boxes.size() != 0)
         @(posedge clock);
      repeat (BOXES * 3 + 20) @(posedge clock);
   endtask

   task automatic write_limit(logic [THR_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      overlap_limit = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Request driver; the offered box stays at the front of the queue until taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) suppress_set(pending_boxes.pop_front());
         if (req_valid && !req_ready) begin
            // Hold the offered box until it is taken.
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_boxes.size() != 0 && $urandom_range(0, 3) != 0) begin
            req_valid <= 1'b1;
            req_box_left <= pending_boxes[0].left;
            req_box_top <= pending_boxes[0].top;
            req_box_right <= pending_boxes[0].right;
            req_box_bottom <= pending_boxes[0].bottom;
            req_box_score <= pending_boxes[0].score;
            req_box_class <= pending_boxes[0].cls;
            req_set_end <= pending_boxes[0].last;
         end else begin
            req_valid <= 1'b0;
            gap_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
                                                     : $urandom_range(0, 3);
         end
      end
   end

   // Result monitor with receiver stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (kept_boxes.size() == 0) begin
               $display("%0t: result with nothing expected, got %h", $time,
                        {rsp_kept_left, rsp_kept_top, rsp_kept_right, rsp_kept_bottom});
               errors++;
            end else begin
               if ({rsp_kept_left, rsp_kept_top, rsp_kept_right, rsp_kept_bottom,
                    rsp_kept_score, rsp_kept_class, rsp_kept_last} !== kept_boxes[0]) begin
                  $display("%0t: kept box expected %h actual %h", $time, kept_boxes[0],
                           {rsp_kept_left, rsp_kept_top, rsp_kept_right, rsp_kept_bottom,
                            rsp_kept_score, rsp_kept_class, rsp_kept_last});
                  errors++;
               end
               void'(kept_boxes.pop_front());
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                       : $urandom_range(1, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_MAX) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Stimulus phases.
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_box_left = '0;
      req_box_top = '0;
      req_box_right = '0;
      req_box_bottom = '0;
      req_box_score = '0;
      req_box_class = '0;
      req_set_end = 1'b0;
      rsp_ready = 1'b0;
      errors = 0;
      idle_cycles = 0;
      hold_off = 0;
      stimulus_done = 0;
      overlap_limit = THR_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: single box, extremes, equal scores, degenerate and disjoint boxes.
      pending_boxes = {pending_boxes, make_box(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 127, 1)};
      pending_boxes = {pending_boxes, make_box(10, 10, 100, 100, 500, 1, 0)};
      pending_boxes = {pending_boxes, make_box(12, 12, 100, 100, 500, 2, 0)};
      pending_boxes = {pending_boxes, make_box(50, 50, 50, 60, 900, 3, 0)};
      pending_boxes = {pending_boxes, make_box(100, 100, 10, 10, 0, 0, 0)};
      pending_boxes = {pending_boxes, make_box(16'hFFFF, 16'hFFFF, 0, 0, 1, 64, 0)};
      pending_boxes = {pending_boxes, make_box(1000, 1000, 2000, 2000, 16'hFFFF, 5, 1)};
      drain();
      write_limit('0);
      pending_boxes = {pending_boxes, make_box(0, 0, 10, 10, 7, 1, 0)};
      pending_boxes = {pending_boxes, make_box(9, 9, 20, 20, 7, 2, 0)};
      pending_boxes = {pending_boxes, make_box(30, 30, 30, 30, 8, 3, 1)};
      drain();
      write_limit(16'hFFFF);
      pending_boxes = {pending_boxes, make_box(0, 0, 10, 10, 7, 1, 0)};
      pending_boxes = {pending_boxes, make_box(0, 0, 10, 10, 7, 2, 1)};
      drain();

      // Overfull set: boxes past the store size are dropped.
      write_limit(THR_RESET);
      queue_random_set(BOXES + 3);
      drain();

      // Receiver holds off while a full set streams in.
      hold_off = 3000;
      queue_random_set(BOXES);
      queue_random_set(10);
      drain();

      // Random sets under several limits.
      for (int phase = 0; phase < 4; phase++) begin
         write_limit(phase == 0 ? 16'd32768 : phase == 1 ? 16'd1 :
                     phase == 2 ? THR_W'($urandom) : 16'd50000);
         for (int n = 0; n < 65; ) begin
            int count;
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(30, BOXES)
                                                : $urandom_range(1, 8);
            queue_random_set(count);
            n += count;
         end
         drain();
      end

      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
